@@ rtl/utrb_pkg.sv @@
// Shared types, constants and pointer helpers for the serial port ring buffers.
// Used by the channel interfaces, the controller, the datapath and the top level.
package utrb_pkg;

  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 64;
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int BYTE_W   = 8;

  typedef logic [TX_PTR_W-1:0] tx_ptr_t;
  typedef logic [RX_PTR_W-1:0] rx_ptr_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  typedef enum logic [1:0] {
    ACT_SEND   = 2'd0,
    ACT_RECV   = 2'd1,
    ACT_ARRIVE = 2'd2,
    ACT_TXE    = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } utrb_cmd_t;

  typedef struct packed {
    action_t action;
    byte_t   data;
  } utrb_item_t;

  typedef struct packed {
    logic  status;
    byte_t data_out;
    logic  line_out_valid;
    logic  arrival_notify;
    logic  empty_request_enabled;
    logic  tx_busy;
  } utrb_result_t;

  function automatic tx_ptr_t tx_advance(tx_ptr_t p);
    return (p == tx_ptr_t'(TX_DEPTH - 1)) ? '0 : tx_ptr_t'(p + 1'b1);
  endfunction

  function automatic rx_ptr_t rx_advance(rx_ptr_t p);
    return (p == rx_ptr_t'(RX_DEPTH - 1)) ? '0 : rx_ptr_t'(p + 1'b1);
  endfunction

endpackage

@@ rtl/utrb_if.sv @@
// Valid/ready channel interfaces for input words and result words.
// Depends on utrb_pkg for the byte width.
interface utrb_in_if;
  import utrb_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  byte_t       data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface utrb_out_if;
  import utrb_pkg::*;
  logic  valid;
  logic  ready;
  logic  status;
  byte_t data_out;
  logic  line_out_valid;
  logic  arrival_notify;
  logic  empty_request_enabled;
  logic  tx_busy;

  modport source (
    output valid, output status, output data_out, output line_out_valid,
    output arrival_notify, output empty_request_enabled, output tx_busy,
    input ready
  );
  modport sink (
    input valid, input status, input data_out, input line_out_valid,
    input arrival_notify, input empty_request_enabled, input tx_busy,
    output ready
  );
endinterface

@@ rtl/uart_tx_rx_ring_buffers.sv @@
// Serial port buffering front end: transmit and receive ring queues.
// Each word is captured with a store read, then executed into the output register.
// The result is registered by the execute step once the output register is free; a waiting
// result holds the execute state, and no new word is accepted until the current one has been
// executed. The capture step serves the registered read of the byte stores ahead of execute.
// Synchronous active-low reset empties both queues and clears the request enable.
module uart_tx_rx_ring_buffers (
  input  logic              clk,
  input  logic              rst_n,
  utrb_in_if.sink           in_ch,
  utrb_out_if.source        out_ch
);
  import utrb_pkg::*;

  utrb_cmd_t    cmd;
  utrb_item_t   item;
  utrb_result_t res;

  assign item.action = action_t'(in_ch.action);
  assign item.data   = in_ch.data_in;

  utrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  utrb_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .item  (item),
    .res   (res)
  );

  assign out_ch.status                = res.status;
  assign out_ch.data_out              = res.data_out;
  assign out_ch.line_out_valid        = res.line_out_valid;
  assign out_ch.arrival_notify        = res.arrival_notify;
  assign out_ch.empty_request_enabled = res.empty_request_enabled;
  assign out_ch.tx_busy               = res.tx_busy;

endmodule

@@ rtl/utrb_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; width and depth are set by the instantiating module.
module utrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/utrb_ctrl.sv @@
// Controller state machine: accepts one word, runs its execute step, owns the
// output valid flag. Depends on utrb_pkg for the state and command types.
module utrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output utrb_pkg::utrb_cmd_t cmd
);
  import utrb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_EXEC)
    else $error("capture not followed by execute state");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("execute did not present a result");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

endmodule

@@ rtl/utrb_dp.sv @@
// Datapath: queue pointers, request enable, both byte stores and the result
// register. Depends on utrb_pkg and utrb_ram; driven by utrb_ctrl commands.
module utrb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  utrb_pkg::utrb_cmd_t    cmd,
  input  utrb_pkg::utrb_item_t   item,
  output utrb_pkg::utrb_result_t res
);
  import utrb_pkg::*;

  tx_ptr_t      tx_wr_ptr_r, tx_wr_ptr_nxt, tx_rd_ptr_r, tx_rd_ptr_nxt;
  rx_ptr_t      rx_wr_ptr_r, rx_wr_ptr_nxt, rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic         req_en_r, req_en_nxt;
  utrb_item_t   item_r;
  utrb_result_t res_r, res_nxt;
  byte_t        tx_rdata, rx_rdata;
  logic         tx_we, rx_we;
  logic         tx_full, tx_empty, rx_full, rx_empty;

  assign tx_full  = tx_advance(tx_wr_ptr_r) == tx_rd_ptr_r;
  assign tx_empty = tx_wr_ptr_r == tx_rd_ptr_r;
  assign rx_full  = rx_advance(rx_wr_ptr_r) == rx_rd_ptr_r;
  assign rx_empty = rx_wr_ptr_r == rx_rd_ptr_r;

  utrb_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk     (clk),
    .we      (tx_we),
    .waddr   (tx_wr_ptr_r),
    .wdata   (item_r.data),
    .re      (cmd.capture),
    .raddr   (tx_rd_ptr_r),
    .rdata_r (tx_rdata)
  );

  utrb_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk     (clk),
    .we      (rx_we),
    .waddr   (rx_wr_ptr_r),
    .wdata   (item_r.data),
    .re      (cmd.capture),
    .raddr   (rx_rd_ptr_r),
    .rdata_r (rx_rdata)
  );

  always_comb begin
    tx_wr_ptr_nxt = tx_wr_ptr_r;
    tx_rd_ptr_nxt = tx_rd_ptr_r;
    rx_wr_ptr_nxt = rx_wr_ptr_r;
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    req_en_nxt    = req_en_r;
    tx_we         = 1'b0;
    rx_we         = 1'b0;
    res_nxt       = '0;
    unique case (item_r.action)
      ACT_SEND: begin
        if (tx_full) begin
          res_nxt.status = 1'b1;
        end else begin
          tx_we         = cmd.execute;
          tx_wr_ptr_nxt = tx_advance(tx_wr_ptr_r);
          req_en_nxt    = 1'b1;
        end
      end
      ACT_RECV: begin
        if (rx_empty) begin
          res_nxt.status = 1'b1;
        end else begin
          res_nxt.data_out = rx_rdata;
          rx_rd_ptr_nxt    = rx_advance(rx_rd_ptr_r);
        end
      end
      ACT_ARRIVE: begin
        if (rx_full) begin
          res_nxt.status = 1'b1;
        end else begin
          rx_we         = cmd.execute;
          rx_wr_ptr_nxt = rx_advance(rx_wr_ptr_r);
        end
        res_nxt.data_out       = item_r.data;
        res_nxt.arrival_notify = 1'b1;
      end
      ACT_TXE: begin
        if (!tx_empty) begin
          res_nxt.data_out       = tx_rdata;
          res_nxt.line_out_valid = 1'b1;
          tx_rd_ptr_nxt          = tx_advance(tx_rd_ptr_r);
        end else begin
          req_en_nxt = 1'b0;
        end
      end
    endcase
    res_nxt.empty_request_enabled = req_en_nxt;
    res_nxt.tx_busy               = tx_wr_ptr_nxt != tx_rd_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      req_en_r    <= 1'b0;
    end else if (cmd.execute) begin
      tx_wr_ptr_r <= tx_wr_ptr_nxt;
      tx_rd_ptr_r <= tx_rd_ptr_nxt;
      rx_wr_ptr_r <= rx_wr_ptr_nxt;
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      req_en_r    <= req_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
    if (cmd.execute) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

  a_tx_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_wr_ptr_r <= tx_ptr_t'(TX_DEPTH - 1)) && (tx_rd_ptr_r <= tx_ptr_t'(TX_DEPTH - 1)))
    else $error("transmit pointer out of range");

  a_rx_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_wr_ptr_r <= rx_ptr_t'(RX_DEPTH - 1)) && (rx_rd_ptr_r <= rx_ptr_t'(RX_DEPTH - 1)))
    else $error("receive pointer out of range");

  a_send_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && item_r.action == ACT_SEND && !tx_full) |=> (req_en_r && !tx_empty))
    else $error("accepted send left transmit queue idle");

endmodule
